### hw/rtl/dwws_pkg.sv
// Shared types and constants for the display window write serializer.
// No dependencies; imported by the front, queue, back and checker files.
`default_nettype none

package dwws_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
   localparam logic [7:0] CMD_ACCESS_CTRL  = 8'h36;

   typedef enum logic [1:0] {
      KIND_WINDOW = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ORIENT = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [8:0] col_start;
      logic [8:0] col_end;
      logic [8:0] row_start;
      logic [8:0] row_end;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } desc_type;

endpackage

`default_nettype wire

### hw/rtl/dwws_front.sv
// Front end: accepts request transactions, holds the orientation register,
// and turns each request of a used type into a descriptor for the queue. Uses dwws_pkg.
`default_nettype none

module dwws_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_type,
   input  wire logic [8:0]        req_col_start,
   input  wire logic [8:0]        req_col_end,
   input  wire logic [8:0]        req_row_start,
   input  wire logic [8:0]        req_row_end,
   input  wire logic [15:0]       req_pixel,
   input  wire logic              q_full,
   output logic                   q_push,
   output dwws_pkg::desc_type     q_desc
);
   import dwws_pkg::*;

   logic [1:0] orient_ff;
   logic [1:0] orient_in;
   logic [7:0] orient_code;

   always_comb begin
      orient_in = csr_we ? csr_wdata : orient_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= 2'd0;
      end else begin
         orient_ff <= orient_in;
      end
   end

   always_comb begin
      case (orient_ff)
         2'd0:    orient_code = 8'h48;
         2'd1:    orient_code = 8'h88;
         2'd2:    orient_code = 8'h28;
         default: orient_code = 8'hE8;
      endcase
   end

   always_comb begin
      q_desc.col_start = req_col_start;
      q_desc.col_end   = req_col_end;
      q_desc.row_start = req_row_start;
      q_desc.row_end   = req_row_end;
      q_desc.byte0     = {req_pixel[15:11], req_pixel[15], 2'b00};
      q_desc.byte1     = {req_pixel[10:5], 2'b00};
      q_desc.byte2     = {req_pixel[4:0], req_pixel[4], 2'b00};
      case (kind_type'(req_type))
         KIND_WINDOW: q_desc.kind = KIND_WINDOW;
         KIND_PIXEL:  q_desc.kind = KIND_PIXEL;
         KIND_ORIENT: begin
            q_desc.kind  = KIND_ORIENT;
            q_desc.byte0 = orient_code;
         end
         default: q_desc.kind = KIND_NONE;
      endcase
   end

   // An unused request type is accepted and dropped without a queue entry.
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full && (q_desc.kind != KIND_NONE);

endmodule

`default_nettype wire

### hw/rtl/dwws_queue.sv
// Short descriptor queue between the front end and the byte sequencer.
// Uses dwws_pkg for the descriptor type.
`default_nettype none

module dwws_queue #(
   parameter int DEPTH = dwws_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dwws_pkg::desc_type push_desc,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output dwws_pkg::desc_type     head_desc
);
   import dwws_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_desc = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### hw/rtl/dwws_back.sv
// Back end: steps through the current descriptor one byte per cycle into
// the registered response stage while it is not stalled. Uses dwws_pkg.
`default_nettype none

module dwws_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_not_empty,
   input  wire dwws_pkg::desc_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_data,
   output logic                   rsp_run_last
);
   import dwws_pkg::*;

   desc_type   cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [3:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_data_ff, out_data_in;
   logic       out_last_ff, out_last_in;

   logic       advance;
   logic [7:0] sel_byte;
   logic       sel_data;
   logic       sel_last;

   always_comb begin
      sel_byte = 8'h00;
      sel_data = 1'b1;
      sel_last = 1'b0;
      case (cur_ff.kind)
         KIND_WINDOW: begin
            case (step_ff)
               4'd0: begin
                  sel_byte = CMD_COLUMN_SET;
                  sel_data = 1'b0;
               end
               4'd1:    sel_byte = {7'd0, cur_ff.col_start[8]};
               4'd2:    sel_byte = cur_ff.col_start[7:0];
               4'd3:    sel_byte = {7'd0, cur_ff.col_end[8]};
               4'd4:    sel_byte = cur_ff.col_end[7:0];
               4'd5: begin
                  sel_byte = CMD_PAGE_SET;
                  sel_data = 1'b0;
               end
               4'd6:    sel_byte = {7'd0, cur_ff.row_start[8]};
               4'd7:    sel_byte = cur_ff.row_start[7:0];
               4'd8:    sel_byte = {7'd0, cur_ff.row_end[8]};
               4'd9:    sel_byte = cur_ff.row_end[7:0];
               default: begin
                  sel_byte = CMD_MEMORY_WRITE;
                  sel_data = 1'b0;
                  sel_last = 1'b1;
               end
            endcase
         end
         KIND_PIXEL: begin
            case (step_ff)
               4'd0:    sel_byte = cur_ff.byte0;
               4'd1:    sel_byte = cur_ff.byte1;
               default: begin
                  sel_byte = cur_ff.byte2;
                  sel_last = 1'b1;
               end
            endcase
         end
         default: begin
            if (step_ff == 4'd0) begin
               sel_byte = CMD_ACCESS_CTRL;
               sel_data = 1'b0;
            end else begin
               sel_byte = cur_ff.byte0;
               sel_last = 1'b1;
            end
         end
      endcase
   end

   assign advance = cur_valid_ff && (!out_valid_ff || rsp_ready);
   assign q_pop   = q_not_empty && (!cur_valid_ff || (advance && sel_last));

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      out_byte_in  = out_byte_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = sel_byte;
         out_data_in  = sel_data;
         out_last_in  = sel_last;
         step_in      = step_ff + 1'b1;
         if (sel_last) begin
            cur_valid_in = 1'b0;
            step_in      = 4'd0;
         end
      end
      if (q_pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         step_in      = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_is_data  = out_data_ff;
   assign rsp_run_last = out_last_ff;

endmodule

`default_nettype wire

### hw/rtl/display_window_write_serializer.sv
// Top level of the display window write serializer.
// Instantiates dwws_front, dwws_queue and dwws_back; uses dwws_pkg.
//
// Each request transaction becomes a run of bytes for a serial TFT panel,
// each tagged command or data, the final byte of a run flagged last. A
// window request yields 11 bytes, a pixel request 3, an orientation request
// 2, and an unused request type none. The back end's response register
// delivers one byte per cycle while the consumer is ready; the front end
// keeps accepting requests while the descriptor queue (QUEUE_DEPTH
// entries) has room. A request's first byte passes through the queue
// entry, the current descriptor register and the response register.
`default_nettype none

module display_window_write_serializer #(
   parameter int QUEUE_DEPTH = dwws_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [8:0]  req_col_start,
   input  wire logic [8:0]  req_col_end,
   input  wire logic [8:0]  req_row_start,
   input  wire logic [8:0]  req_row_end,
   input  wire logic [15:0] req_pixel,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_data,
   output logic             rsp_run_last
);
   import dwws_pkg::*;

   desc_type push_desc;
   desc_type head_desc;
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_not_empty;

   dwws_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_col_start (req_col_start),
      .req_col_end   (req_col_end),
      .req_row_start (req_row_start),
      .req_row_end   (req_row_end),
      .req_pixel     (req_pixel),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_desc        (push_desc)
   );

   dwws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_desc (head_desc)
   );

   dwws_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_head       (head_desc),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire

### hw/rtl/dwws_checker.sv
// Port-level checker for the display window write serializer, with its bind.
// Uses dwws_pkg for the command codes.
`default_nettype none

module dwws_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_is_data,
   input wire logic       rsp_run_last
);
   import dwws_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_is_data) && $stable(rsp_run_last))
      else $error("A stalled response transaction changed.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_cmd_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_data |-> rsp_out_byte == CMD_COLUMN_SET
         || rsp_out_byte == CMD_PAGE_SET || rsp_out_byte == CMD_MEMORY_WRITE
         || rsp_out_byte == CMD_ACCESS_CTRL)
      else $error("Unknown command byte.");

   a_last_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last && !rsp_is_data |-> rsp_out_byte == CMD_MEMORY_WRITE)
      else $error("Only memory write may end a run as a command.");

   a_after_col_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_data && rsp_out_byte != CMD_MEMORY_WRITE
         |-> !rsp_run_last)
      else $error("A run ended on a leading command byte.");

endmodule

bind display_window_write_serializer dwws_checker u_dwws_checker (.*);

`default_nettype wire

### sim/dwws_checker.sv
// Checker for the display window write serializer: watches the request, response
// and register ports, predicts every byte of each run and compares in order.
// Depends on dwws_pkg for the request kinds and the command codes.
`timescale 1ns / 1ps

module dwws_tb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [8:0]  req_col_start,
   input  logic [8:0]  req_col_end,
   input  logic [8:0]  req_row_start,
   input  logic [8:0]  req_row_end,
   input  logic [15:0] req_pixel,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_is_data,
   input  logic        rsp_run_last,
   output int          fail_count,
   output int          pending_count
);
   import dwws_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       run_last;
   } link_byte_type;

   link_byte_type expected_bytes[$];
   logic [1:0] orientation;

   task automatic push_link_byte(input logic [7:0] b, input logic dat, input logic last);
      link_byte_type entry;
      entry.out_byte = b;
      entry.is_data = dat;
      entry.run_last = last;
      expected_bytes.push_back(entry);
   endtask

   task automatic serialize_request(input logic [1:0] kind, input logic [8:0] cs,
                                    input logic [8:0] ce, input logic [8:0] rs,
                                    input logic [8:0] re, input logic [15:0] pix);
      logic [7:0] orient_byte;
      case (kind_type'(kind))
         KIND_WINDOW: begin
            push_link_byte(CMD_COLUMN_SET, 1'b0, 1'b0);
            push_link_byte({7'd0, cs[8]}, 1'b1, 1'b0);
            push_link_byte(cs[7:0], 1'b1, 1'b0);
            push_link_byte({7'd0, ce[8]}, 1'b1, 1'b0);
            push_link_byte(ce[7:0], 1'b1, 1'b0);
            push_link_byte(CMD_PAGE_SET, 1'b0, 1'b0);
            push_link_byte({7'd0, rs[8]}, 1'b1, 1'b0);
            push_link_byte(rs[7:0], 1'b1, 1'b0);
            push_link_byte({7'd0, re[8]}, 1'b1, 1'b0);
            push_link_byte(re[7:0], 1'b1, 1'b0);
            push_link_byte(CMD_MEMORY_WRITE, 1'b0, 1'b1);
         end
         KIND_PIXEL: begin
            // The top bit of red and of blue is copied into bit 2 of its byte; green fills bits 7:2.
            push_link_byte({pix[15:11], pix[15], 2'b00}, 1'b1, 1'b0);
            push_link_byte({pix[10:5], 2'b00}, 1'b1, 1'b0);
            push_link_byte({pix[4:0], pix[4], 2'b00}, 1'b1, 1'b1);
         end
         KIND_ORIENT: begin
            case (orientation)
               2'd0: orient_byte = 8'h48;
               2'd1: orient_byte = 8'h88;
               2'd2: orient_byte = 8'h28;
               default: orient_byte = 8'hE8;
            endcase
            push_link_byte(CMD_ACCESS_CTRL, 1'b0, 1'b0);
            push_link_byte(orient_byte, 1'b1, 1'b1);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      link_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         orientation = 2'd0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected byte %h is_data %b run_last %b", rsp_out_byte,
                      rsp_is_data, rsp_run_last);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_is_data !== want.is_data) begin
                  $error("is_data: expected %b, actual %b", want.is_data, rsp_is_data);
                  fail_count++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $error("run_last: expected %b, actual %b", want.run_last, rsp_run_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            serialize_request(req_type, req_col_start, req_col_end, req_row_start,
                              req_row_end, req_pixel);
         end
         if (csr_we) begin
            orientation = csr_wdata;
         end
      end
      pending_count = expected_bytes.size();
   end

endmodule

### sim/display_window_write_serializer_tb.sv
// Top of the display window write serializer testbench: clock, reset, request
// and register stimulus, response back-pressure and the final verdict.
// Depends on dwws_pkg, display_window_write_serializer and dwws_tb_checker.
`timescale 1ns / 1ps

module display_window_write_serializer_tb;
   import dwws_pkg::*;

   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 40;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_wdata;
   logic        req_valid;
   logic        req_ready;
   kind_type    req_type;
   logic [8:0]  req_col_start;
   logic [8:0]  req_col_end;
   logic [8:0]  req_row_start;
   logic [8:0]  req_row_end;
   logic [15:0] req_pixel;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_data;
   logic        rsp_run_last;
   int          fail_count;
   int          pending_count;

   int req_idle_pct;
   int rsp_idle_pct;
   int holds_requested;
   int holds_done;

   display_window_write_serializer dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_col_start (req_col_start),
      .req_col_end   (req_col_end),
      .req_row_start (req_row_start),
      .req_row_end   (req_row_end),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_data   (rsp_is_data),
      .rsp_run_last  (rsp_run_last)
   );

   dwws_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_col_start (req_col_start),
      .req_col_end   (req_col_end),
      .req_row_start (req_row_start),
      .req_row_end   (req_row_end),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_data   (rsp_is_data),
      .rsp_run_last  (rsp_run_last),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Response side: random back-pressure, with long hold-offs on request.
   initial begin
      rsp_ready = 1'b0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done < holds_requested) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic offer_request(input kind_type kind, input logic [8:0] cs,
                                input logic [8:0] ce, input logic [8:0] rs,
                                input logic [8:0] re, input logic [15:0] pix);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_col_start <= cs;
      req_col_end <= ce;
      req_row_start <= rs;
      req_row_end <= re;
      req_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_link();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_orientation(input logic [1:0] value);
      drain_link();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_requests(input int count);
      kind_type kind;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 55) kind = KIND_PIXEL;
         else if (pick < 80) kind = KIND_WINDOW;
         else if (pick < 92) kind = KIND_ORIENT;
         else kind = KIND_NONE;
         offer_request(kind, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom),
                       16'($urandom));
      end
   endtask

   initial begin
      logic [1:0] phase_orient [8];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 2'd0;
      req_valid = 1'b0;
      req_type = KIND_WINDOW;
      req_col_start = 9'd0;
      req_col_end = 9'd0;
      req_row_start = 9'd0;
      req_row_end = 9'd0;
      req_pixel = 16'd0;
      req_idle_pct = 22;
      rsp_idle_pct = 22;
      holds_requested = 0;
      phase_orient = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: reset orientation, window extremes, pixel corners, unused kind, other orientations.
      offer_request(KIND_ORIENT, 9'd0, 9'd0, 9'd0, 9'd0, 16'd0);
      offer_request(KIND_WINDOW, 9'd0, 9'd0, 9'd0, 9'd0, 16'd0);
      offer_request(KIND_WINDOW, 9'd0, 9'd479, 9'd0, 9'd479, 16'hFFFF);
      offer_request(KIND_WINDOW, 9'd511, 9'd511, 9'd511, 9'd511, 16'd0);
      offer_request(KIND_WINDOW, 9'd479, 9'd1, 9'd300, 9'd256, 16'h1234);
      offer_request(KIND_NONE, 9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF);
      offer_request(KIND_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0000);
      offer_request(KIND_PIXEL, 9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF);
      offer_request(KIND_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h8000);
      offer_request(KIND_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0010);
      offer_request(KIND_NONE, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0000);
      offer_request(KIND_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'hF800);
      offer_request(KIND_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h07E0);
      offer_request(KIND_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h001F);
      offer_request(KIND_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h7FEF);
      offer_request(KIND_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0400);
      for (int o = 1; o < 4; o++) begin
         write_orientation(2'(o));
         offer_request(KIND_ORIENT, 9'd0, 9'd0, 9'd0, 9'd0, 16'd0);
      end

      // Random part in phases, each under its own orientation.
      for (int phase = 0; phase < 8; phase++) begin
         write_orientation(phase_orient[phase]);
         req_idle_pct = (phase == 2) ? 0 : 22;
         rsp_idle_pct = (phase == 2) ? 0 : 22;
         if (phase == 4) holds_requested++;
         send_random_requests(PHASE_ITEMS);
      end

      drain_link();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/dwws_pkg.sv
hw/rtl/dwws_front.sv
hw/rtl/dwws_queue.sv
hw/rtl/dwws_back.sv
hw/rtl/display_window_write_serializer.sv
hw/rtl/dwws_checker.sv
sim/dwws_checker.sv
sim/display_window_write_serializer_tb.sv
